FILE: design/knps_pkg.sv
// ----------------------------------------------------------------------------
// knps_pkg
// Shared types and codes for the k-nearest point search block.
// ----------------------------------------------------------------------------
package knps_pkg;

  // request opcodes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // width of the neighbor count register
  localparam int NN_BITS  = 5;
  localparam logic [NN_BITS-1:0] NN_RESET = 5'd4;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  // control that travels with a candidate down the chain
  typedef struct packed {
    logic valid;
    logic skip;
    logic last;
  } cand_ctl_t;

endpackage

FILE: design/knps_cell.sv
// ----------------------------------------------------------------------------
// knps_cell
// One slot of the picked list. Holds one picked position and marks any
// candidate passing through that matches it.
// ----------------------------------------------------------------------------
module knps_cell #(
  parameter int PW = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pick_clr,
  input  logic                pick_we,
  input  logic [PW-1:0]       pick_pt,
  input  knps_pkg::cand_ctl_t cand_in,
  input  logic [PW-1:0]       pt_in,
  output knps_pkg::cand_ctl_t cand_out,
  output logic [PW-1:0]       pt_out
);

  logic          held_vld;
  logic [PW-1:0] held_pt;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_vld       <= 1'b0;
      cand_out.valid <= 1'b0;
    end else begin
      cand_out.valid <= cand_in.valid;
      if (pick_clr) begin
        held_vld <= 1'b0;
      end else if (pick_we) begin
        held_vld <= 1'b1;
      end
    end
    if (pick_we) begin
      held_pt <= pick_pt;
    end
    cand_out.skip <= cand_in.skip | (held_vld && (held_pt == pt_in));
    cand_out.last <= cand_in.last;
    pt_out        <= pt_in;
  end

endmodule

FILE: design/knps_dist.sv
// ----------------------------------------------------------------------------
// knps_dist
// Three-stage squared distance: abs differences, squares, sum.
// ----------------------------------------------------------------------------
module knps_dist #(
  parameter int CB = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [2*CB-1:0]      q,
  input  knps_pkg::cand_ctl_t  ctl_in,
  input  logic [2*CB-1:0]      pt_in,
  output knps_pkg::cand_ctl_t  ctl_out,
  output logic [2*CB-1:0]      pt_out,
  output logic [2*CB:0]        d_sq
);

  knps_pkg::cand_ctl_t ctl_s1, ctl_s2;
  logic [2*CB-1:0]     pt_s1, pt_s2;
  logic [CB-1:0]       dx, dy;
  logic [2*CB-1:0]     sqx, sqy;
  logic [CB-1:0]       ax, ay, bx, by;

  assign ax = pt_in[CB-1:0];
  assign ay = pt_in[2*CB-1:CB];
  assign bx = q[CB-1:0];
  assign by = q[2*CB-1:CB];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s1.valid  <= 1'b0;
      ctl_s2.valid  <= 1'b0;
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_s1.valid  <= ctl_in.valid;
      ctl_s2.valid  <= ctl_s1.valid;
      ctl_out.valid <= ctl_s2.valid;
    end

    dx           <= (ax > bx) ? ax - bx : bx - ax;
    dy           <= (ay > by) ? ay - by : by - ay;
    ctl_s1.skip  <= ctl_in.skip;
    ctl_s1.last  <= ctl_in.last;
    pt_s1        <= pt_in;

    sqx          <= (2*CB)'(dx) * (2*CB)'(dx);
    sqy          <= (2*CB)'(dy) * (2*CB)'(dy);
    ctl_s2.skip  <= ctl_s1.skip;
    ctl_s2.last  <= ctl_s1.last;
    pt_s2        <= pt_s1;

    d_sq         <= (2*CB+1)'(sqx) + (2*CB+1)'(sqy);
    ctl_out.skip <= ctl_s2.skip;
    ctl_out.last <= ctl_s2.last;
    pt_out       <= pt_s2;
  end

endmodule

FILE: design/k_nearest_point_search.sv
// ----------------------------------------------------------------------------
// k_nearest_point_search
// Brute-force k-nearest-neighbor search over a store of 2D points.
// ----------------------------------------------------------------------------
// Clear and load requests are handled in the idle state; a load into a full
// store is dropped. A query returns num_neighbors results (0 counts as 1,
// values above MAX_K count as MAX_K). Each pick streams the whole store, one
// point per cycle out of the store memory, which has one write and one read
// port, down a chain of MAX_K cells that hold the positions already picked,
// then through a three-stage distance unit into a running minimum. With an
// empty store no scan is run and each pick is issued straight from the emit
// state. A new request is taken only once the previous query has issued its
// last result. Results wait in an output register, so the scan for the next
// pick runs while a result is pending.
// ----------------------------------------------------------------------------
module k_nearest_point_search #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_K      = 16,
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   opcode,
  input  logic [COORD_BITS-1:0]        point_x,
  input  logic [COORD_BITS-1:0]        point_y,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [COORD_BITS-1:0]        pick_x,
  output logic [COORD_BITS-1:0]        pick_y,
  output logic [2*COORD_BITS:0]        pick_dist_sq,
  output logic                         found,
  output logic                         last_pick,
  // neighbor count register
  input  logic                         cfg_we,
  input  logic [knps_pkg::NN_BITS-1:0] cfg_wdata
);

  localparam int PW = 2 * COORD_BITS;          // packed point {y, x}
  localparam int DW = 2 * COORD_BITS + 1;      // squared distance
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int KW = $clog2(MAX_K + 1);

  knps_pkg::state_t state;

  logic [knps_pkg::NN_BITS-1:0] nn;
  logic [CW-1:0] count;
  logic [CW-1:0] cnt_m1;
  logic [KW-1:0] k_reg, k_next;
  logic [KW-1:0] j;          // pick number within the query
  logic [KW-1:0] picks;      // picks that found a candidate
  logic          j_last;

  logic [PW-1:0] q;
  logic [PW-1:0] best, prev;
  logic [DW-1:0] best_d, prev_d;
  logic          have;

  // store memory
  logic [PW-1:0] store [MAX_POINTS];
  logic [AW-1:0] rd_idx;
  logic [PW-1:0] rd_data;
  logic          rd_vld, rd_last;
  logic          scan_last;

  logic acc, acc_load, acc_query, emit_fire, best_upd;

  // candidate chain
  knps_pkg::cand_ctl_t chain_ctl [MAX_K+1];
  logic [PW-1:0]       chain_pt  [MAX_K+1];

  knps_pkg::cand_ctl_t d_ctl;
  logic [PW-1:0]       d_pt;
  logic [DW-1:0]       d_dist;

  assign in_ready  = (state == knps_pkg::ST_IDLE);
  assign acc       = in_valid && in_ready;
  assign acc_load  = acc && (opcode == knps_pkg::OP_LOAD) && (count < CW'(MAX_POINTS));
  assign acc_query = acc && (opcode == knps_pkg::OP_QUERY);

  assign cnt_m1    = count - 1'b1;
  assign scan_last = (rd_idx == cnt_m1[AW-1:0]);
  assign j_last    = (j == k_reg - KW'(1));
  assign emit_fire = (state == knps_pkg::ST_EMIT) && (!out_valid || out_ready);
  assign best_upd  = d_ctl.valid && !d_ctl.skip && (!have || (d_dist < best_d));

  // clamp the neighbor count to 1..MAX_K
  always_comb begin
    if (nn == '0) begin
      k_next = KW'(1);
    end else if (32'(nn) > MAX_K) begin
      k_next = KW'(MAX_K);
    end else begin
      k_next = KW'(nn);
    end
  end

  // store: written on load, read one entry a cycle while scanning
  always_ff @(posedge clk) begin
    if (acc_load) begin
      store[count[AW-1:0]] <= {point_y, point_x};
    end
    rd_data <= store[rd_idx];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= knps_pkg::ST_IDLE;
      nn        <= knps_pkg::NN_RESET;
      count     <= '0;
      out_valid <= 1'b0;
      rd_vld    <= 1'b0;
      picks     <= '0;
      j         <= '0;
      have      <= 1'b0;
    end else begin
      if (cfg_we) begin
        nn <= cfg_wdata;
      end
      rd_vld <= (state == knps_pkg::ST_SCAN);
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (best_upd) begin
        have <= 1'b1;
      end

      unique case (state)
        knps_pkg::ST_IDLE: begin
          if (acc) begin
            unique case (opcode)
              knps_pkg::OP_CLEAR: count <= '0;
              knps_pkg::OP_LOAD: begin
                if (acc_load) begin
                  count <= count + 1'b1;
                end
              end
              knps_pkg::OP_QUERY: begin
                picks <= '0;
                j     <= '0;
                have  <= 1'b0;
                state <= (count == '0) ? knps_pkg::ST_EMIT : knps_pkg::ST_SCAN;
              end
              default: ;  // unused opcode: no effect
            endcase
          end
        end
        knps_pkg::ST_SCAN: begin
          if (scan_last) begin
            state <= knps_pkg::ST_WAIT;
          end
        end
        knps_pkg::ST_WAIT: begin
          // last candidate of the pass leaves the distance unit
          if (d_ctl.valid && d_ctl.last) begin
            state <= knps_pkg::ST_EMIT;
          end
        end
        knps_pkg::ST_EMIT: begin
          if (emit_fire) begin
            j    <= j + 1'b1;
            have <= 1'b0;
            if (have) begin
              picks <= picks + 1'b1;
            end
            if (j_last) begin
              state <= knps_pkg::ST_IDLE;
            end else begin
              state <= (count == '0) ? knps_pkg::ST_EMIT : knps_pkg::ST_SCAN;
            end
          end
        end
        default: state <= knps_pkg::ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rd_last <= scan_last;
    if (state == knps_pkg::ST_SCAN) begin
      rd_idx <= rd_idx + 1'b1;
    end
    if (acc_query) begin
      q      <= {point_y, point_x};
      k_reg  <= k_next;
      prev   <= '0;
      prev_d <= '0;
      rd_idx <= '0;
    end
    if (best_upd) begin
      best   <= d_pt;
      best_d <= d_dist;
    end
    if (emit_fire) begin
      rd_idx    <= '0;
      last_pick <= j_last;
      found     <= have;
      if (have) begin
        pick_x       <= best[COORD_BITS-1:0];
        pick_y       <= best[PW-1:COORD_BITS];
        pick_dist_sq <= best_d;
        prev         <= best;
        prev_d       <= best_d;
      end else begin
        // nothing eligible: repeat the previous pick (zeros if none)
        pick_x       <= prev[COORD_BITS-1:0];
        pick_y       <= prev[PW-1:COORD_BITS];
        pick_dist_sq <= prev_d;
      end
    end
  end

  // chain entry; the query position itself is skipped here
  assign chain_ctl[0].valid = rd_vld;
  assign chain_ctl[0].skip  = (rd_data == q);
  assign chain_ctl[0].last  = rd_last;
  assign chain_pt[0]        = rd_data;

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    knps_cell #(
      .PW (PW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .pick_clr (acc_query),
      .pick_we  (emit_fire && have && (picks == KW'(i))),
      .pick_pt  (best),
      .cand_in  (chain_ctl[i]),
      .pt_in    (chain_pt[i]),
      .cand_out (chain_ctl[i+1]),
      .pt_out   (chain_pt[i+1])
    );
  end

  knps_dist #(
    .CB (COORD_BITS)
  ) u_dist (
    .clk     (clk),
    .rst     (rst),
    .q       (q),
    .ctl_in  (chain_ctl[MAX_K]),
    .pt_in   (chain_pt[MAX_K]),
    .ctl_out (d_ctl),
    .pt_out  (d_pt),
    .d_sq    (d_dist)
  );

  // candidates reach the minimum only during a scan pass
  a_dist_in_scan: assert property (@(posedge clk) disable iff (rst)
    d_ctl.valid |-> (state == knps_pkg::ST_SCAN || state == knps_pkg::ST_WAIT))
    else $error("candidate left distance unit outside a scan pass");

  // successful picks never outnumber picks issued
  a_picks_le_j: assert property (@(posedge clk) disable iff (rst)
    picks <= j)
    else $error("pick count ahead of pick number");

  // a found neighbor is never at the query position
  a_found_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (pick_dist_sq != '0))
    else $error("found pick at zero distance");

endmodule

FILE: tb/k_nearest_point_search_test.sv
// ----------------------------------------------------------------------------
// k_nearest_point_search_test
// Self-checking bench for the brute-force k-nearest point search block.
// Requests go in through a queue-fed driver. A monitor predicts the picks
// of every accepted query and checks each returned result against the
// oldest pending pick, field by field.
// ----------------------------------------------------------------------------
module k_nearest_point_search_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_POINTS = 1024;
  localparam int MAX_K      = 16;
  localparam int COORD_BITS = 12;

  // opcode 3 has no meaning; the block must drop it without a trace
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // quiet cycles after the last result before the block counts as idle
  localparam int DRAIN_CYCLES   = MAX_K + 24;
  // a full-store pick runs with no handshake on either side
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic [COORD_BITS-1:0]   coord_t;
  typedef logic [2*COORD_BITS-1:0] point_t;   // {y, x}
  typedef logic [2*COORD_BITS:0]   dist_t;

  typedef struct packed {
    logic [1:0] op;
    coord_t     x;
    coord_t     y;
  } request_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    dist_t  dist_sq;
    logic   found;
    logic   last;
  } pick_t;

  // --------------------------------------------------------------------------
  // DUT hookup; every input holds a known value from time zero
  // --------------------------------------------------------------------------
  logic                         clk;
  logic                         rst       = 1'b1;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  logic [1:0]                   opcode    = knps_pkg::OP_CLEAR;
  coord_t                       point_x   = '0;
  coord_t                       point_y   = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  coord_t                       pick_x;
  coord_t                       pick_y;
  dist_t                        pick_dist_sq;
  logic                         found;
  logic                         last_pick;
  logic                         cfg_we    = 1'b0;
  logic [knps_pkg::NN_BITS-1:0] cfg_wdata = '0;

  k_nearest_point_search #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_K      (MAX_K),
    .COORD_BITS (COORD_BITS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .point_x      (point_x),
    .point_y      (point_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pick_x       (pick_x),
    .pick_y       (pick_y),
    .pick_dist_sq (pick_dist_sq),
    .found        (found),
    .last_pick    (last_pick),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  request_t           req_queue[$];      // requests not yet presented
  pick_t              pending_picks[$];  // predicted results, oldest first
  logic               req_taken = 1'b0;  // request accepted at the last rising edge
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 fail_count = 0;
  int                 stall_cycles = 0;
  int                 req_made = 0;      // requests queued, ignored codes not counted
  int                 gen_count = 0;     // store fill as seen by the generator

  // shadow copy of the block's state
  point_t                       cand_mem[MAX_POINTS];
  int                           cand_count = 0;
  logic [knps_pkg::NN_BITS-1:0] nn_setting = knps_pkg::NN_RESET;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic dist_t sq_dist(input point_t a, input point_t b);
    int dx, dy;
    dx = int'(a[COORD_BITS-1:0]) - int'(b[COORD_BITS-1:0]);
    dy = int'(a[2*COORD_BITS-1:COORD_BITS]) - int'(b[2*COORD_BITS-1:COORD_BITS]);
    return dist_t'(dx * dx + dy * dy);
  endfunction

  // One query: k passes over the store, each taking the closest point that is
  // neither the query position nor a position already picked. Strict less-than
  // keeps the earliest-loaded point on a tie. A pass that finds nothing repeats
  // the previous pick (or zeros) with found low.
  task automatic search_neighbors(input point_t q);
    int     k, j, i, m;
    point_t taken[$];
    point_t prev, best, c;
    dist_t  best_d, d;
    logic   have, skip;
    pick_t  p;
    if (nn_setting == 0)
      k = 1;
    else if (nn_setting > MAX_K)
      k = MAX_K;
    else
      k = int'(nn_setting);
    prev = '0;
    for (j = 0; j < k; j++) begin
      have   = 1'b0;
      best   = '0;
      best_d = '0;
      for (i = 0; i < cand_count; i++) begin
        c    = cand_mem[i];
        skip = (c == q);
        for (m = 0; m < taken.size(); m++)
          if (taken[m] == c) skip = 1'b1;
        if (!skip) begin
          d = sq_dist(q, c);
          if (!have || d < best_d) begin
            have   = 1'b1;
            best   = c;
            best_d = d;
          end
        end
      end
      if (have) begin
        taken = {taken, best};
        prev  = best;
      end else begin
        best   = prev;
        best_d = (taken.size() != 0) ? sq_dist(q, prev) : '0;
      end
      p.x       = best[COORD_BITS-1:0];
      p.y       = best[2*COORD_BITS-1:COORD_BITS];
      p.dist_sq = best_d;
      p.found   = have;
      p.last    = (j == k - 1);
      pending_picks = {pending_picks, p};
    end
  endtask

  task automatic apply_request(input logic [1:0] op, input coord_t x, input coord_t y);
    case (op)
      knps_pkg::OP_CLEAR: cand_count = 0;
      knps_pkg::OP_LOAD: begin
        // loads into a full store are dropped
        if (cand_count < MAX_POINTS) begin
          cand_mem[cand_count] = {y, x};
          cand_count++;
        end
      end
      knps_pkg::OP_QUERY: search_neighbors({y, x});
      default: ;
    endcase
  endtask

  task automatic check_field(input string field, input dist_t want, input dist_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued requests at the falling edge. Valid stays up with
  // a steady payload until the request is taken; between requests the sender
  // idles at random.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    request_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (req_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        r = req_queue.pop_front();
        in_valid <= 1'b1;
        opcode   <= r.op;
        point_x  <= r.x;
        point_y  <= r.y;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: at each rising edge, check a returned result first, then predict
  // for an accepted request, so picks keep their order even when both
  // handshakes land on the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pick_t want;
    if (rst) begin
      req_taken  <= 1'b0;
      cand_count = 0;
      nn_setting = knps_pkg::NN_RESET;
    end else begin
      req_taken <= in_valid && in_ready;
      if (cfg_we)
        nn_setting = cfg_wdata;
      if (out_valid && out_ready) begin
        if (pending_picks.size() == 0) begin
          $error("result with no pick pending: x=%0d y=%0d dist=%0d",
                 pick_x, pick_y, pick_dist_sq);
          fail_count++;
        end else begin
          want = pending_picks.pop_front();
          check_field("pick_x", dist_t'(want.x), dist_t'(pick_x));
          check_field("pick_y", dist_t'(want.y), dist_t'(pick_y));
          check_field("pick_dist_sq", want.dist_sq, pick_dist_sq);
          check_field("found", dist_t'(want.found), dist_t'(found));
          check_field("last_pick", dist_t'(want.last), dist_t'(last_pick));
        end
      end
      if (in_valid && in_ready)
        apply_request(opcode, point_x, point_y);
    end
  end

  // Watchdog: a run of cycles with no handshake on either side means a hang.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("** k_nearest_point_search: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_req(input logic [1:0] op, input coord_t x, input coord_t y);
    request_t r;
    r.op = op;
    r.x  = x;
    r.y  = y;
    req_queue = {req_queue, r};
    if (op != OP_UNUSED) req_made++;
    if (op == knps_pkg::OP_CLEAR) gen_count = 0;
    if (op == knps_pkg::OP_LOAD && gen_count < MAX_POINTS) gen_count++;
  endtask

  // Block is idle: every request presented, every pick returned, plus a margin.
  // Sampled at the falling edge so the monitor's updates have settled.
  task automatic wait_drained();
    while (req_queue.size() != 0 || in_valid || pending_picks.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_neighbors(input logic [knps_pkg::NN_BITS-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mode 0: anywhere; mode 1: tight cluster (ties, duplicates);
  // mode 2: corners only (many duplicates, few distinct points)
  function automatic coord_t pick_coord(input int mode, input coord_t base);
    case (mode)
      0:       return coord_t'($urandom);
      1:       return base + coord_t'($urandom_range(0, 6));
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  // One scene: mostly clear, a handful of loads and a few queries around them.
  // Now and then just noise: stray codes, queries on whatever is stored.
  task automatic add_scene();
    int     n, mode;
    coord_t bx, by, qx, qy;
    point_t loaded[$];
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 4))
        push_req(2'($urandom), coord_t'($urandom), coord_t'($urandom));
    end else begin
      if (gen_count > 40 || $urandom_range(0, 7) != 0)
        push_req(knps_pkg::OP_CLEAR, coord_t'($urandom), coord_t'($urandom));
      mode = $urandom_range(0, 2);
      bx   = coord_t'($urandom);
      by   = coord_t'($urandom);
      n    = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(0, 16);
      repeat (n) begin
        qx = pick_coord(mode, bx);
        qy = pick_coord(mode, by);
        loaded = {loaded, point_t'({qy, qx})};
        push_req(knps_pkg::OP_LOAD, qx, qy);
      end
      repeat ($urandom_range(1, 3)) begin
        // a query sitting on a stored point exercises the self-skip
        if (loaded.size() != 0 && $urandom_range(0, 2) == 0) begin
          {qy, qx} = loaded[$urandom_range(0, loaded.size() - 1)];
        end else begin
          qx = pick_coord(mode, bx);
          qy = pick_coord(mode, by);
        end
        push_req(knps_pkg::OP_QUERY, qx, qy);
      end
    end
  endtask

  task automatic run_random_phase(input logic [knps_pkg::NN_BITS-1:0] neighbors,
                                  input int count);
    int stop_at;
    wait_drained();
    write_neighbors(neighbors);
    stop_at = req_made + count;
    while (req_made < stop_at) begin
      // sometimes hold the sender until every pick is back
      if ($urandom_range(0, 19) == 0) wait_drained();
      add_scene();
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sender idles 12%, receiver 64%
    send_idle_pct = 12;
    recv_idle_pct = 64;

    // directed, neighbor count at its reset value of 4
    push_req(knps_pkg::OP_QUERY, 12'd100, 12'd200);   // empty store: all zeros
    push_req(OP_UNUSED, '1, '1);                      // ignored
    push_req(knps_pkg::OP_LOAD, 12'd0, 12'd0);
    push_req(knps_pkg::OP_LOAD, '1, '1);
    push_req(knps_pkg::OP_LOAD, '1, 12'd0);
    push_req(knps_pkg::OP_LOAD, 12'd0, '1);
    push_req(knps_pkg::OP_LOAD, 12'd0, 12'd0);        // duplicate
    push_req(knps_pkg::OP_LOAD, 12'd2048, 12'd2048);
    push_req(knps_pkg::OP_QUERY, 12'd0, 12'd0);       // self skipped, corner tie
    push_req(knps_pkg::OP_QUERY, '1, '1);             // largest distance
    push_req(knps_pkg::OP_QUERY, 12'd2048, 12'd2048);
    push_req(knps_pkg::OP_QUERY, 12'd2048, 12'd2047);
    wait_drained();

    // more picks than distinct points: repeats with found low
    write_neighbors(5'd16);
    push_req(knps_pkg::OP_QUERY, 12'd1, 12'd1);
    push_req(knps_pkg::OP_CLEAR, '1, '1);
    push_req(knps_pkg::OP_QUERY, '1, 12'd0);          // cleared store
    push_req(knps_pkg::OP_LOAD, 12'd10, 12'd10);
    push_req(knps_pkg::OP_LOAD, 12'd12, 12'd10);
    push_req(knps_pkg::OP_LOAD, 12'd8, 12'd10);       // ties with the one before
    push_req(knps_pkg::OP_LOAD, 12'd10, 12'd10);
    push_req(knps_pkg::OP_QUERY, 12'd10, 12'd10);
    wait_drained();

    // zero neighbors counts as one
    write_neighbors(5'd0);
    push_req(knps_pkg::OP_QUERY, 12'd11, 12'd10);
    push_req(knps_pkg::OP_QUERY, 12'd10, 12'd10);
    wait_drained();

    write_neighbors(5'd17);                           // above MAX_K counts as MAX_K
    push_req(knps_pkg::OP_QUERY, 12'd0, 12'd0);
    push_req(knps_pkg::OP_CLEAR, 12'd0, 12'd0);

    // random scenes
    run_random_phase(5'd0, 40);
    run_random_phase(5'd31, 40);
    run_random_phase(5'($urandom_range(2, 15)), 40);

    wait_drained();
    send_idle_pct = 64;
    recv_idle_pct = 12;
    run_random_phase(5'd16, 40);
    run_random_phase(5'd1, 40);
    run_random_phase(5'($urandom_range(17, 30)), 40);

    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(5'd2, 40);
    run_random_phase(5'($urandom_range(0, 31)), 40);
    run_random_phase(5'd4, 40);

    wait_drained();
    if (fail_count == 0)
      $display("** k_nearest_point_search: PASSED **");
    else
      $display("** k_nearest_point_search: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
design/knps_pkg.sv
design/knps_cell.sv
design/knps_dist.sv
design/k_nearest_point_search.sv
tb/k_nearest_point_search_test.sv
